@@ hdl/sprmb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprmb_pkg - shared types and constants of the stereo meter ballistics
// Level, age and timing widths, command and register codes, the sequencer
// states and the control words that pass between the lanes and the merge.
// ----------------------------------------------------------------------------
package sprmb_pkg;

   // field widths
   localparam int LEVEL_BITS   = 16;
   localparam int ELAPSED_BITS = 16;
   localparam int DECAY_BITS   = 16;
   localparam int HOLD_BITS    = 16;
   localparam int AGE_BITS     = 16;

   // one linear unit is 2^14 in Q2.14
   localparam int UNIT_SHIFT = 14;

   // decay step = elapsed * 2^14 / decay, exact quotient width
   localparam int STEP_BITS      = ELAPSED_BITS + UNIT_SHIFT;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_CYCLES     = (STEP_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   localparam int DIV_NUM_BITS   = DIV_CYCLES * DIV_RADIX_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);

   // common width for comparing a level against a decay step
   localparam int FALL_BITS = (LEVEL_BITS > STEP_BITS) ? LEVEL_BITS : STEP_BITS;

   // register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (LEVEL_BITS > DECAY_BITS) ? LEVEL_BITS : DECAY_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_MS    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_MS     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEREO_MODE = 2'd3;

   // register reset values
   localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RESET = LEVEL_BITS'(1 << UNIT_SHIFT);
   localparam logic [DECAY_BITS-1:0] DECAY_MS_RESET  = DECAY_BITS'(2000);
   localparam logic [HOLD_BITS-1:0]  HOLD_MS_RESET   = HOLD_BITS'(1500);

   typedef logic [LEVEL_BITS-1:0] level_type;

   typedef enum logic [1:0] {
      CMD_STEREO = 2'd0,
      CMD_JOINT  = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY,
      ST_REPORT
   } state_type;

   // what one lane found about its incoming levels
   typedef struct packed {
      logic pk_gt_peak;
      logic pk_gt_hold;
      logic rm_gt_rms;
   } lane_flag_type;

   // what the merge tells one lane to do
   typedef struct packed {
      logic upd;
      logic tick;
      logic take_peak;
      logic take_hold;
      logic take_rms;
   } lane_ctl_type;

endpackage : sprmb_pkg
`default_nettype wire

@@ hdl/sprmb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprmb_if - request and response channels of the stereo meter
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface sprmb_req_if import sprmb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [LEVEL_BITS-1:0]   left_peak;
   logic [LEVEL_BITS-1:0]   right_peak;
   logic [LEVEL_BITS-1:0]   left_rms;
   logic [LEVEL_BITS-1:0]   right_rms;
   logic [ELAPSED_BITS-1:0] elapsed_ms;

   modport source (
      output valid, command, left_peak, right_peak, left_rms, right_rms, elapsed_ms,
      input  ready
   );
   modport sink (
      input  valid, command, left_peak, right_peak, left_rms, right_rms, elapsed_ms,
      output ready
   );
endinterface : sprmb_req_if

interface sprmb_rsp_if import sprmb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] peak_level_left;
   logic [LEVEL_BITS-1:0] peak_level_right;
   logic [LEVEL_BITS-1:0] rms_level_left;
   logic [LEVEL_BITS-1:0] rms_level_right;
   logic [LEVEL_BITS-1:0] hold_level_left;
   logic [LEVEL_BITS-1:0] hold_level_right;

   modport source (
      output valid, peak_level_left, peak_level_right, rms_level_left,
             rms_level_right, hold_level_left, hold_level_right,
      input  ready
   );
   modport sink (
      input  valid, peak_level_left, peak_level_right, rms_level_left,
             rms_level_right, hold_level_left, hold_level_right,
      output ready
   );
endinterface : sprmb_rsp_if
`default_nettype wire

@@ hdl/sprmb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprmb_div - iterative decay step divider
// Restoring division of elapsed * 2^14 by decay_ms, two quotient bits a cycle.
// A decay time of zero divides by one.
// ----------------------------------------------------------------------------
module sprmb_div import sprmb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ELAPSED_BITS-1:0] elapsed,
   input  logic [DECAY_BITS-1:0]   decay,
   output logic                    done,
   output logic [STEP_BITS-1:0]    quotient
);

   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    done_ff;
   logic [DIV_NUM_BITS-1:0] quo_ff;
   logic [DECAY_BITS-1:0]   rem_ff;
   logic [DECAY_BITS-1:0]   div_ff;

   logic [DIV_NUM_BITS-1:0] quo_in;
   logic [DECAY_BITS-1:0]   rem_in;
   logic [DECAY_BITS:0]     trial;

   // two restoring steps per cycle
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
         trial  = {rem_in, quo_in[DIV_NUM_BITS-1]};
         quo_in = {quo_in[DIV_NUM_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial     = trial - {1'b0, div_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DECAY_BITS-1:0];
      end
   end

   // iteration count and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= DIV_CNT_BITS'(DIV_CYCLES);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // partial remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= DIV_NUM_BITS'({elapsed, {UNIT_SHIFT{1'b0}}});
         rem_ff <= '0;
         div_ff <= (decay == '0) ? DECAY_BITS'(1) : decay;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[STEP_BITS-1:0];

endmodule : sprmb_div
`default_nettype wire

@@ hdl/sprmb_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprmb_lane - ballistics of one channel
// Holds peak, RMS, hold value and hold age; reports how incoming levels
// compare and applies the rise or the decay that the merge orders.
// ----------------------------------------------------------------------------
module sprmb_lane import sprmb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lane_ctl_type            ctl,
   input  level_type               pk,
   input  level_type               rm,
   input  logic [STEP_BITS-1:0]    step,
   input  logic [ELAPSED_BITS-1:0] elapsed,
   input  logic [HOLD_BITS-1:0]    hold_ms,
   output lane_flag_type           flags,
   output level_type               peak,
   output level_type               rms,
   output level_type               hold
);

   level_type             peak_ff, rms_ff, hold_ff;
   logic [AGE_BITS-1:0]   age_ff;
   level_type             peak_in, rms_in, hold_in;
   logic [AGE_BITS-1:0]   age_in;
   logic [AGE_BITS:0]     age_sum;
   logic [AGE_BITS-1:0]   age_sat;

   // linear fall floored at zero
   function automatic level_type fall_level(input level_type lvl,
                                            input logic [STEP_BITS-1:0] stp);
      logic [FALL_BITS-1:0] lvl_ext;
      logic [FALL_BITS-1:0] stp_ext;
      logic [FALL_BITS-1:0] diff;
      lvl_ext = FALL_BITS'(lvl);
      stp_ext = FALL_BITS'(stp);
      diff    = lvl_ext - stp_ext;
      return (lvl_ext > stp_ext) ? LEVEL_BITS'(diff) : '0;
   endfunction

   // comparisons for the merge
   assign flags.pk_gt_peak = pk > peak_ff;
   assign flags.pk_gt_hold = pk > hold_ff;
   assign flags.rm_gt_rms  = rm > rms_ff;

   // saturating hold age
   assign age_sum = {1'b0, age_ff} + (AGE_BITS + 1)'(elapsed);
   assign age_sat = age_sum[AGE_BITS] ? '1 : age_sum[AGE_BITS-1:0];

   // next state
   always_comb begin
      peak_in = peak_ff;
      rms_in  = rms_ff;
      hold_in = hold_ff;
      age_in  = age_ff;
      if (ctl.tick) begin
         peak_in = fall_level(peak_ff, step);
         rms_in  = fall_level(rms_ff, step);
         age_in  = age_sat;
         if (AGE_BITS'(age_sat) >= AGE_BITS'(hold_ms)) begin
            hold_in = '0;
         end
      end else if (ctl.upd) begin
         if (ctl.take_peak) begin
            peak_in = pk;
         end
         if (ctl.take_hold) begin
            hold_in = pk;
            age_in  = '0;
         end
         if (ctl.take_rms) begin
            rms_in = rm;
         end
      end
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         rms_ff  <= '0;
         hold_ff <= '0;
         age_ff  <= '0;
      end else begin
         peak_ff <= peak_in;
         rms_ff  <= rms_in;
         hold_ff <= hold_in;
         age_ff  <= age_in;
      end
   end

   assign peak = peak_ff;
   assign rms  = rms_ff;
   assign hold = hold_ff;

endmodule : sprmb_lane
`default_nettype wire

@@ hdl/sprmb_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprmb_merge - combines what both lanes found
// Separate updates keep each lane's own decisions; joint updates write both
// lanes when either is exceeded. Ticks go to both lanes.
// ----------------------------------------------------------------------------
module sprmb_merge import sprmb_pkg::*; (
   input  logic          apply,
   input  cmd_type       cmd,
   input  lane_flag_type flags_left,
   input  lane_flag_type flags_right,
   output lane_ctl_type  ctl_left,
   output lane_ctl_type  ctl_right
);

   logic any_peak, any_hold, any_rms;

   assign any_peak = flags_left.pk_gt_peak | flags_right.pk_gt_peak;
   assign any_hold = flags_left.pk_gt_hold | flags_right.pk_gt_hold;
   assign any_rms  = flags_left.rm_gt_rms  | flags_right.rm_gt_rms;

   always_comb begin
      ctl_left  = '0;
      ctl_right = '0;
      case (cmd)
         CMD_STEREO: begin
            ctl_left.upd        = apply;
            ctl_left.take_peak  = flags_left.pk_gt_peak;
            ctl_left.take_hold  = flags_left.pk_gt_peak & flags_left.pk_gt_hold;
            ctl_left.take_rms   = flags_left.rm_gt_rms;
            ctl_right.upd       = apply;
            ctl_right.take_peak = flags_right.pk_gt_peak;
            ctl_right.take_hold = flags_right.pk_gt_peak & flags_right.pk_gt_hold;
            ctl_right.take_rms  = flags_right.rm_gt_rms;
         end
         CMD_JOINT: begin
            ctl_left.upd        = apply;
            ctl_left.take_peak  = any_peak;
            ctl_left.take_hold  = any_peak & any_hold;
            ctl_left.take_rms   = any_rms;
            ctl_right           = ctl_left;
         end
         CMD_TICK: begin
            ctl_left.tick  = apply;
            ctl_right.tick = apply;
         end
         default: begin
            ctl_left  = '0;
            ctl_right = '0;
         end
      endcase
   end

endmodule : sprmb_merge
`default_nettype wire

@@ hdl/stereo_peak_rms_meter_ballistics_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter_ballistics_top - two-channel meter ballistics
// Level updates, joint updates and decay ticks on peak, RMS and held peak.
//
//   channel  | direction | contents
//   ---------+-----------+-------------------------------------------------
//   req_bus  | in        | command, peak and RMS levels, elapsed ms
//   rsp_bus  | out       | peak, RMS and hold levels of both channels
//   csr_*    | in        | max_level, decay_ms, hold_ms, stereo_mode writes
//
// One word at a time. An update passes the apply and report states before the next
// acceptance; a tick first waits in the divide state for the decay step divider.
// Results sit in an output register, so a new word is taken while the last
// result still waits. Synchronous reset clears all levels, holds and ages.
// ----------------------------------------------------------------------------
module stereo_peak_rms_meter_ballistics_top import sprmb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   sprmb_req_if.sink                 req_bus,
   sprmb_rsp_if.source               rsp_bus,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration
   level_type             max_level_ff;
   logic [DECAY_BITS-1:0] decay_ms_ff;
   logic [HOLD_BITS-1:0]  hold_ms_ff;
   logic                  stereo_mode_ff;

   // sequencer
   state_type state_ff, state_in;
   logic      accept, div_start, apply, out_load;

   // captured word
   cmd_type                 cmd_ff;
   level_type               pk_left_ff, pk_right_ff, rm_left_ff, rm_right_ff;
   logic [ELAPSED_BITS-1:0] elapsed_ff;

   // clamped and mode-selected lane inputs
   level_type lp, rp, lr, rr, mp, mr;
   level_type pk_left_in, pk_right_in, rm_left_in, rm_right_in;

   // datapath links
   logic                 div_done;
   logic [STEP_BITS-1:0] step;
   lane_flag_type        flags_left, flags_right;
   lane_ctl_type         ctl_left, ctl_right;
   level_type            peak_left, peak_right, rms_left, rms_right;
   level_type            hold_left, hold_right;

   // output register
   logic      rsp_valid_ff;
   level_type out_peak_left_ff, out_peak_right_ff;
   level_type out_rms_left_ff, out_rms_right_ff;
   level_type out_hold_left_ff, out_hold_right_ff;

   function automatic level_type clamp_level(input level_type x, input level_type lim);
      return (x > lim) ? lim : x;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff   <= MAX_LEVEL_RESET;
         decay_ms_ff    <= DECAY_MS_RESET;
         hold_ms_ff     <= HOLD_MS_RESET;
         stereo_mode_ff <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index)
            REG_MAX_LEVEL:   max_level_ff   <= csr_wdata[LEVEL_BITS-1:0];
            REG_DECAY_MS:    decay_ms_ff    <= csr_wdata[DECAY_BITS-1:0];
            REG_HOLD_MS:     hold_ms_ff     <= csr_wdata[HOLD_BITS-1:0];
            REG_STEREO_MODE: stereo_mode_ff <= csr_wdata[0];
            default:         stereo_mode_ff <= stereo_mode_ff;
         endcase
      end
   end

   // clamp, then pick what each lane sees
   assign lp = clamp_level(req_bus.left_peak, max_level_ff);
   assign rp = clamp_level(req_bus.right_peak, max_level_ff);
   assign lr = clamp_level(req_bus.left_rms, max_level_ff);
   assign rr = clamp_level(req_bus.right_rms, max_level_ff);
   assign mp = (lp > rp) ? lp : rp;
   assign mr = (lr > rr) ? lr : rr;

   always_comb begin
      pk_left_in  = lp;
      pk_right_in = rp;
      rm_left_in  = lr;
      rm_right_in = rr;
      case (cmd_type'(req_bus.command))
         CMD_STEREO: begin
            if (!stereo_mode_ff) begin
               pk_left_in  = mp;
               pk_right_in = mp;
               rm_left_in  = mr;
               rm_right_in = mr;
            end
         end
         CMD_JOINT: begin
            pk_right_in = lp;
            rm_right_in = lr;
         end
         default: begin
            pk_left_in  = lp;
            pk_right_in = rp;
         end
      endcase
   end

   // word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= cmd_type'(req_bus.command);
         pk_left_ff  <= pk_left_in;
         pk_right_ff <= pk_right_in;
         rm_left_ff  <= rm_left_in;
         rm_right_ff <= rm_right_in;
         elapsed_ff  <= req_bus.elapsed_ms;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = (cmd_type'(req_bus.command) == CMD_TICK) ? ST_DIVIDE : ST_APPLY;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      accept        = 1'b0;
      div_start     = 1'b0;
      apply         = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            accept        = req_bus.valid;
            div_start     = req_bus.valid && (cmd_type'(req_bus.command) == CMD_TICK);
         end
         ST_DIVIDE: begin
            req_bus.ready = 1'b0;
         end
         ST_APPLY: begin
            apply = 1'b1;
         end
         ST_REPORT: begin
            out_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   // decay step
   sprmb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .elapsed  (req_bus.elapsed_ms),
      .decay    (decay_ms_ff),
      .done     (div_done),
      .quotient (step)
   );

   // channel lanes
   sprmb_lane u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_left),
      .pk      (pk_left_ff),
      .rm      (rm_left_ff),
      .step    (step),
      .elapsed (elapsed_ff),
      .hold_ms (hold_ms_ff),
      .flags   (flags_left),
      .peak    (peak_left),
      .rms     (rms_left),
      .hold    (hold_left)
   );

   sprmb_lane u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_right),
      .pk      (pk_right_ff),
      .rm      (rm_right_ff),
      .step    (step),
      .elapsed (elapsed_ff),
      .hold_ms (hold_ms_ff),
      .flags   (flags_right),
      .peak    (peak_right),
      .rms     (rms_right),
      .hold    (hold_right)
   );

   // lane decisions
   sprmb_merge u_merge (
      .apply       (apply),
      .cmd         (cmd_ff),
      .flags_left  (flags_left),
      .flags_right (flags_right),
      .ctl_left    (ctl_left),
      .ctl_right   (ctl_right)
   );

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_peak_left_ff  <= peak_left;
         out_peak_right_ff <= peak_right;
         out_rms_left_ff   <= rms_left;
         out_rms_right_ff  <= rms_right;
         out_hold_left_ff  <= hold_left;
         out_hold_right_ff <= hold_right;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.peak_level_left  = out_peak_left_ff;
   assign rsp_bus.peak_level_right = out_peak_right_ff;
   assign rsp_bus.rms_level_left   = out_rms_left_ff;
   assign rsp_bus.rms_level_right  = out_rms_right_ff;
   assign rsp_bus.hold_level_left  = out_hold_left_ff;
   assign rsp_bus.hold_level_right = out_hold_right_ff;

endmodule : stereo_peak_rms_meter_ballistics_top
`default_nettype wire

@@ hdl/sprmb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprmb_checker - port-level checks of the stereo meter
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module sprmb_checker import sprmb_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire level_type peak_level_left,
   input wire level_type rms_level_right,
   input wire level_type hold_level_left
);

   // a word is worked on for a while before the next is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
      else $error("request taken again too soon after a word");

   // no response is pending in the first cycle out of reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid just after reset");

   // a stalled response stays offered
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a stalled response word does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(peak_level_left) &&
                                     $stable(rms_level_right) &&
                                     $stable(hold_level_left)))
      else $error("response word changed while stalled");

endmodule : sprmb_checker

bind stereo_peak_rms_meter_ballistics_top sprmb_checker u_sprmb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .peak_level_left (rsp_bus.peak_level_left),
   .rms_level_right (rsp_bus.rms_level_right),
   .hold_level_left (rsp_bus.hold_level_left)
);
`default_nettype wire

@@ verif/tb_stereo_peak_rms_meter_ballistics_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_peak_rms_meter_ballistics_top - self-checking bench of the meter
// Drives level updates, joint updates, decay ticks and idle commands through
// the request channel under several register settings. A behavioural copy of
// the meter predicts every response word, which is then checked field by
// field. The sender works in random bursts, and the receiver stalls on a
// shifting pattern with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_stereo_peak_rms_meter_ballistics_top;
   import sprmb_pkg::*;

   localparam int CLK_HALF        = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int LONG_HOLD_OFF   = 400;
   localparam int SETTLE_CYCLES   = 24;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASES          = 9;
   localparam int WORDS_PER_PHASE = 135;
   localparam int MAX_REPORTS     = 10;
   localparam logic [AGE_BITS-1:0] AGE_SATURATED = '1;

   typedef struct packed {
      cmd_type                 command;
      level_type               left_peak;
      level_type               right_peak;
      level_type               left_rms;
      level_type               right_rms;
      logic [ELAPSED_BITS-1:0] elapsed_ms;
   } meter_word_type;

   typedef struct packed {
      level_type peak_l;
      level_type peak_r;
      level_type rms_l;
      level_type rms_r;
      level_type hold_l;
      level_type hold_r;
   } meter_levels_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   sprmb_req_if req_bus ();
   sprmb_rsp_if rsp_bus ();

   stereo_peak_rms_meter_ballistics_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies held by the bench
   level_type               cfg_max_level;
   logic [DECAY_BITS-1:0]   cfg_decay_ms;
   logic [HOLD_BITS-1:0]    cfg_hold_ms;
   logic                    cfg_stereo;

   // meter state: index 0 left, index 1 right
   level_type               peak_lvl [2];
   level_type               rms_lvl  [2];
   level_type               hold_lvl [2];
   logic [AGE_BITS-1:0]     hold_age [2];

   meter_word_type          pending_words [$];
   meter_levels_type        expected_levels [$];
   meter_word_type          offered;

   int burst_left        = 1;
   int gap_left          = 0;
   int hold_off_requests = 0;
   int hold_offs_served  = 0;
   int hold_off_left     = 0;
   int pattern_pos       = 0;
   int idle_cycles       = 0;
   int failures          = 0;
   logic [15:0] stall_pattern = '1;

   // clock
   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // ---------------------------------------------------------------- predictor

   function automatic level_type clamp_to_max(level_type v);
      return (v > cfg_max_level) ? cfg_max_level : v;
   endfunction

   function automatic level_type decay_level(level_type v, longint unsigned step);
      if (64'(v) > step) return level_type'(64'(v) - step);
      return '0;
   endfunction

   // a level rises at once; a rising peak above the hold restarts the hold
   function automatic void raise_lane(int ch, level_type pk, level_type rm);
      if (pk > peak_lvl[ch]) begin
         peak_lvl[ch] = pk;
         if (pk > hold_lvl[ch]) begin
            hold_lvl[ch] = pk;
            hold_age[ch] = '0;
         end
      end
      if (rm > rms_lvl[ch]) rms_lvl[ch] = rm;
   endfunction

   function automatic void predict_levels(meter_word_type w);
      level_type        lp, rp, lr, rr, mp, mr;
      longint unsigned  divisor, step, age;
      meter_levels_type r;
      lp = clamp_to_max(w.left_peak);
      rp = clamp_to_max(w.right_peak);
      lr = clamp_to_max(w.left_rms);
      rr = clamp_to_max(w.right_rms);
      case (w.command)
         CMD_STEREO: begin
            // mono mode merges each pair by maximum
            if (!cfg_stereo) begin
               mp = (lp > rp) ? lp : rp;
               mr = (lr > rr) ? lr : rr;
               lp = mp;
               rp = mp;
               lr = mr;
               rr = mr;
            end
            raise_lane(0, lp, lr);
            raise_lane(1, rp, rr);
         end
         CMD_JOINT: begin
            // either channel exceeded writes both
            if (lp > peak_lvl[0] || lp > peak_lvl[1]) begin
               peak_lvl[0] = lp;
               peak_lvl[1] = lp;
               if (lp > hold_lvl[0] || lp > hold_lvl[1]) begin
                  hold_lvl[0] = lp;
                  hold_lvl[1] = lp;
                  hold_age[0] = '0;
                  hold_age[1] = '0;
               end
            end
            if (lr > rms_lvl[0] || lr > rms_lvl[1]) begin
               rms_lvl[0] = lr;
               rms_lvl[1] = lr;
            end
         end
         CMD_TICK: begin
            // linear fall by elapsed * unit / decay, zero decay taken as one
            divisor = (cfg_decay_ms == '0) ? 64'd1 : 64'(cfg_decay_ms);
            step    = (64'(w.elapsed_ms) << UNIT_SHIFT) / divisor;
            for (int ch = 0; ch < 2; ch++) begin
               peak_lvl[ch] = decay_level(peak_lvl[ch], step);
               rms_lvl[ch]  = decay_level(rms_lvl[ch], step);
               age          = 64'(hold_age[ch]) + 64'(w.elapsed_ms);
               hold_age[ch] = (age > 64'(AGE_SATURATED)) ? AGE_SATURATED : AGE_BITS'(age);
               if (hold_age[ch] >= cfg_hold_ms) hold_lvl[ch] = '0;
            end
         end
         default: ;
      endcase
      r.peak_l = peak_lvl[0];
      r.peak_r = peak_lvl[1];
      r.rms_l  = rms_lvl[0];
      r.rms_r  = rms_lvl[1];
      r.hold_l = hold_lvl[0];
      r.hold_r = hold_lvl[1];
      expected_levels.insert(expected_levels.size(), r);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic meter_word_type make_word(cmd_type c, level_type lp, level_type rp,
                                                level_type lr, level_type rr,
                                                logic [ELAPSED_BITS-1:0] el);
      meter_word_type w;
      w.command    = c;
      w.left_peak  = lp;
      w.right_peak = rp;
      w.left_rms   = lr;
      w.right_rms  = rr;
      w.elapsed_ms = el;
      return w;
   endfunction

   // append a word to the sender's queue
   function automatic void queue_word(meter_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // levels cluster round the clamp and near zero, with the full range too
   function automatic level_type rand_level();
      case ($urandom_range(0, 4))
         0:       return level_type'($urandom);
         1:       return cfg_max_level;
         2:       return level_type'(cfg_max_level + $urandom_range(0, 8) - 4);
         3:       return level_type'($urandom_range(0, 255));
         default: return level_type'($urandom_range(0, cfg_max_level));
      endcase
   endfunction

   // short ticks let holds live a while; some land right on the hold time
   function automatic logic [ELAPSED_BITS-1:0] rand_elapsed();
      case ($urandom_range(0, 4))
         0:       return ELAPSED_BITS'($urandom_range(0, 20));
         1, 2:    return ELAPSED_BITS'($urandom_range(0, 400));
         3:       return ELAPSED_BITS'(cfg_hold_ms + $urandom_range(0, 4) - 2);
         default: return ELAPSED_BITS'($urandom);
      endcase
   endfunction

   function automatic meter_word_type rand_word();
      meter_word_type w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      w.command = CMD_STEREO;
      else if (pick < 65) w.command = CMD_JOINT;
      else if (pick < 95) w.command = CMD_TICK;
      else                w.command = CMD_NONE;
      w.left_peak  = rand_level();
      w.right_peak = rand_level();
      w.left_rms   = rand_level();
      w.right_rms  = rand_level();
      w.elapsed_ms = rand_elapsed();
      return w;
   endfunction

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         REG_MAX_LEVEL:   cfg_max_level = data;
         REG_DECAY_MS:    cfg_decay_ms  = data;
         REG_HOLD_MS:     cfg_hold_ms   = data;
         REG_STEREO_MODE: cfg_stereo    = data[0];
         default: ;
      endcase
   endtask

   task automatic set_registers(level_type max_lvl, logic [DECAY_BITS-1:0] decay,
                                logic [HOLD_BITS-1:0] hold, logic [CSR_DATA_BITS-1:0] mode);
      write_register(REG_MAX_LEVEL, max_lvl);
      write_register(REG_DECAY_MS, decay);
      write_register(REG_HOLD_MS, hold);
      write_register(REG_STEREO_MODE, mode);
   endtask

   task automatic random_registers();
      level_type               max_lvl;
      logic [DECAY_BITS-1:0]   decay;
      logic [HOLD_BITS-1:0]    hold;
      case ($urandom_range(0, 3))
         0:       max_lvl = '1;
         1:       max_lvl = MAX_LEVEL_RESET;
         2:       max_lvl = level_type'($urandom_range(0, 255));
         default: max_lvl = level_type'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       decay = DECAY_BITS'($urandom_range(0, 4));
         1:       decay = DECAY_BITS'($urandom_range(1, 4000));
         2:       decay = '1;
         default: decay = DECAY_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       hold = HOLD_BITS'($urandom_range(0, 50));
         1:       hold = HOLD_BITS'($urandom_range(0, 2000));
         2:       hold = '1;
         default: hold = HOLD_BITS'($urandom);
      endcase
      set_registers(max_lvl, decay, hold, CSR_DATA_BITS'($urandom));
   endtask

   // block is idle once every word is in and every response is out
   task automatic wait_until_drained(int extra);
      do @(negedge clock);
      while (pending_words.size() != 0 || expected_levels.size() != 0 || req_bus.valid);
      repeat (extra) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_levels(offered);
         if (req_bus.valid && !req_bus.ready) begin
            // word still on offer
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            offered = pending_words.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.command    <= offered.command;
            req_bus.left_peak  <= offered.left_peak;
            req_bus.right_peak <= offered.right_peak;
            req_bus.left_rms   <= offered.left_rms;
            req_bus.right_rms  <= offered.right_rms;
            req_bus.elapsed_ms <= offered.elapsed_ms;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) == 0) gap_left = 0;
               else gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      meter_levels_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.peak_l = rsp_bus.peak_level_left;
            got.peak_r = rsp_bus.peak_level_right;
            got.rms_l  = rsp_bus.rms_level_left;
            got.rms_r  = rsp_bus.rms_level_right;
            got.hold_l = rsp_bus.hold_level_left;
            got.hold_r = rsp_bus.hold_level_right;
            if (expected_levels.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: unexpected response word %p", $realtime, got);
            end else begin
               want = expected_levels.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("%0t: level mismatch, expected pk %h/%h rms %h/%h hold %h/%h",
                              $realtime, want.peak_l, want.peak_r, want.rms_l,
                              want.rms_r, want.hold_l, want.hold_r);
                     $display("   got pk %h/%h rms %h/%h hold %h/%h",
                              got.peak_l, got.peak_r, got.rms_l, got.rms_r,
                              got.hold_l, got.hold_r);
                  end
               end
            end
         end
         // long hold-off on request, else a stall pattern renewed each time its position wraps
         if (hold_off_left == 0 && hold_offs_served != hold_off_requests) begin
            hold_offs_served++;
            hold_off_left = LONG_HOLD_OFF;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (pattern_pos == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pattern = '1;
                  1:       stall_pattern = 16'($urandom | $urandom);
                  2:       stall_pattern = 16'($urandom);
                  default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
               endcase
            end
            rsp_bus.ready <= stall_pattern[pattern_pos % 16];
            pattern_pos    = (pattern_pos + 1) % 64;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("tb_stereo_peak_rms_meter_ballistics_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // known values before the first edge
      reset              = 1'b1;
      csr_wen            = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_NONE;
      req_bus.left_peak  = '0;
      req_bus.right_peak = '0;
      req_bus.left_rms   = '0;
      req_bus.right_rms  = '0;
      req_bus.elapsed_ms = '0;
      rsp_bus.ready      = 1'b0;

      cfg_max_level = MAX_LEVEL_RESET;
      cfg_decay_ms  = DECAY_MS_RESET;
      cfg_hold_ms   = HOLD_MS_RESET;
      cfg_stereo    = 1'b1;
      for (int ch = 0; ch < 2; ch++) begin
         peak_lvl[ch] = '0;
         rms_lvl[ch]  = '0;
         hold_lvl[ch] = '0;
         hold_age[ch] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset settings
      queue_word(make_word(CMD_STEREO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0));
      queue_word(make_word(CMD_STEREO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0));
      queue_word(make_word(CMD_TICK, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 16'd100));
      queue_word(make_word(CMD_STEREO, 16'd16384, 16'd15000, 16'd16000, 16'd0, 16'd7));
      queue_word(make_word(CMD_JOINT, 16'd16000, 16'hFFFF, 16'd16100, 16'hFFFF, 16'd9));
      queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1500));
      queue_word(make_word(CMD_JOINT, 16'd40000, 16'd0, 16'd50000, 16'd0, 16'd0));
      queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
      queue_word(make_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      queue_word(make_word(CMD_NONE, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF));
      queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1));
      queue_word(make_word(CMD_STEREO, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0));
      queue_word(make_word(CMD_JOINT, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0));
      // hold survives one millisecond short of the hold time, clears on it
      queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1499));
      queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1));
      queue_word(make_word(CMD_STEREO, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA));
      wait_until_drained(SETTLE_CYCLES);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               // widest clamp, fastest decay, no hold, mono
               set_registers('1, DECAY_BITS'(1), '0, CSR_DATA_BITS'(0));
               queue_word(make_word(CMD_STEREO, 16'hFFFF, 16'h1234, 16'h0000, 16'h8000, 16'd0));
               queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1));
               queue_word(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0));
               queue_word(make_word(CMD_STEREO, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                    16'h5555));
               queue_word(make_word(CMD_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                    16'h0000));
            end
            // clamp at zero, slowest decay, longest hold, stereo with stray upper bits
            1: set_registers('0, '1, '1, CSR_DATA_BITS'($urandom) | CSR_DATA_BITS'(1));
            2: begin
               // zero decay time, and the receiver backs the block up
               set_registers(MAX_LEVEL_RESET, '0, HOLD_MS_RESET, CSR_DATA_BITS'(1));
               hold_off_requests++;
            end
            default: random_registers();
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++) queue_word(rand_word());
         wait_until_drained(SETTLE_CYCLES);
      end

      wait_until_drained(DRAIN_CYCLES);
      if (failures == 0) $display("tb_stereo_peak_rms_meter_ballistics_top passed");
      else               $display("tb_stereo_peak_rms_meter_ballistics_top failed");
      $finish;
   end

endmodule : tb_stereo_peak_rms_meter_ballistics_top
